FILE: rtl/mcpw_pkg.sv
// shared types and constants of the multi-channel progress watchdog
// no dependencies; used by the interfaces, the channel table and the top level
package mcpw_pkg;

    localparam int TICK_W  = 64;
    localparam int TIME_W  = 64;
    localparam int LIMIT_W = 32;
    localparam int COUNT_W = 5;
    localparam int CH_W    = 4;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 5'd16;
    localparam logic [LIMIT_W-1:0] STALL_LIMIT_RST   = 32'd10000;
    localparam logic [LIMIT_W-1:0] POLL_GAP_RST      = 32'd5000;

    localparam logic [ACT_W-1:0] ACT_ARM    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POLL   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_GAP      = 2'd2;

    typedef enum logic [2:0] {
        ST_ARMED    = 3'd0,
        ST_POLLED   = 3'd1,
        ST_REBASED  = 3'd2,
        ST_PROGRESS = 3'd3,
        ST_STALLED  = 3'd4,
        ST_HANG     = 3'd5,
        ST_BAD      = 3'd6,
        ST_LATCHED  = 3'd7
    } status_t;

    typedef struct packed {
        logic lc_we;
        logic pt_we;
    } wr_ctl_t;

endpackage

FILE: rtl/mcpw_ifs.sv
// request, result and register write channels of the watchdog
// depends on mcpw_pkg
interface mcpw_item_if;
    logic                            valid;
    logic                            ready;
    logic [mcpw_pkg::ACT_W-1:0]      action;
    logic [mcpw_pkg::CH_W-1:0]       channel;
    logic [mcpw_pkg::TICK_W-1:0]     tick_count;
    logic [mcpw_pkg::TIME_W-1:0]     now_ms;

    modport source (output valid, action, channel, tick_count, now_ms, input ready);
    modport sink   (input valid, action, channel, tick_count, now_ms, output ready);
endinterface

interface mcpw_result_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      status;
    logic [mcpw_pkg::CH_W-1:0]       channel_out;
    logic [mcpw_pkg::TIME_W-1:0]     stall_ms;
    logic [mcpw_pkg::TIME_W-1:0]     max_stall_ms;
    logic                            hang;

    modport source (output valid, status, channel_out, stall_ms, max_stall_ms, hang,
                    input ready);
    modport sink   (input valid, status, channel_out, stall_ms, max_stall_ms, hang,
                    output ready);
endinterface

interface mcpw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mcpw_pkg::CFG_IDX_W-1:0]  index;
    logic [mcpw_pkg::LIMIT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mcpw_chan_mem.sv
// per-channel table of last counter value and progress time
// registered read with write-through forwarding; depends on mcpw_pkg
module mcpw_chan_mem #(
    parameter int CHANNELS = 16,
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    input  mcpw_pkg::wr_ctl_t             wr_ctl,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [mcpw_pkg::TICK_W-1:0]   wr_counter,
    input  logic [mcpw_pkg::TIME_W-1:0]   wr_time,
    output logic [mcpw_pkg::TICK_W-1:0]   rd_counter,
    output logic [mcpw_pkg::TIME_W-1:0]   rd_time
);

    logic [mcpw_pkg::TICK_W-1:0] lc_mem [CHANNELS];
    logic [mcpw_pkg::TIME_W-1:0] pt_mem [CHANNELS];
    logic [mcpw_pkg::TICK_W-1:0] rd_counter_reg;
    logic [mcpw_pkg::TIME_W-1:0] rd_time_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.lc_we)
        begin
            lc_mem[wr_addr] <= wr_counter;
        end
        if (wr_ctl.pt_we)
        begin
            pt_mem[wr_addr] <= wr_time;
        end
    end

    // same-edge write goes straight to the read register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_counter_reg <= (wr_ctl.lc_we && (wr_addr == rd_addr)) ? wr_counter
                                                                     : lc_mem[rd_addr];
            rd_time_reg    <= (wr_ctl.pt_we && (wr_addr == rd_addr)) ? wr_time
                                                                     : pt_mem[rd_addr];
        end
    end

    assign rd_counter = rd_counter_reg;
    assign rd_time    = rd_time_reg;

endmodule

FILE: rtl/multi_channel_progress_watchdog.sv
// multi-channel progress watchdog: request held in the input stage, result in the output stage
// throughput one request per cycle while result.ready holds, set by the table's registered read
// port and the update of the table and the poll/stall state
// reset clears valid flags, armed mask, poll time, rebase flag, max stall, hang flag and loads
// register defaults; table entries stay undefined until a channel is armed, no clearing pass
// depends on mcpw_pkg, mcpw_ifs and mcpw_chan_mem
module multi_channel_progress_watchdog #(
    parameter int CHANNELS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    mcpw_item_if.sink      item,
    mcpw_result_if.source  result,
    mcpw_cfg_if.sink       cfg
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // register file
    logic [mcpw_pkg::COUNT_W-1:0]  channel_count_reg;
    logic [mcpw_pkg::LIMIT_W-1:0]  stall_limit_reg;
    logic [mcpw_pkg::LIMIT_W-1:0]  poll_gap_reg;

    // input stage
    logic                          s1_valid_reg;
    logic [mcpw_pkg::ACT_W-1:0]    s1_action_reg;
    logic [mcpw_pkg::CH_W-1:0]     s1_channel_reg;
    logic [mcpw_pkg::TICK_W-1:0]   s1_tick_reg;
    logic [mcpw_pkg::TIME_W-1:0]   s1_now_reg;

    // watchdog state
    logic [CHANNELS-1:0]           armed_mask_reg, armed_mask_next;
    logic [mcpw_pkg::TIME_W-1:0]   last_poll_reg, last_poll_next;
    logic                          rebase_reg, rebase_next;
    logic [mcpw_pkg::TIME_W-1:0]   max_stall_reg, max_stall_next;
    logic                          hang_reg, hang_next;

    // output stage
    logic                          out_valid_reg;
    mcpw_pkg::status_t             status_reg, status_next;
    logic [mcpw_pkg::CH_W-1:0]     chout_reg, chout_next;
    logic [mcpw_pkg::TIME_W-1:0]   stall_reg, stall_next;

    logic                          s1_fire;
    logic                          in_fire;
    logic [IDX_W-1:0]              rd_addr;
    logic [IDX_W-1:0]              s1_addr;
    mcpw_pkg::wr_ctl_t             wr_ctl;
    logic [mcpw_pkg::TICK_W-1:0]   rd_counter;
    logic [mcpw_pkg::TIME_W-1:0]   rd_time;
    logic                          ch_ok;
    logic [mcpw_pkg::TIME_W-1:0]   gap;
    logic [mcpw_pkg::TIME_W-1:0]   stall;

    assign s1_fire     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !s1_valid_reg || s1_fire;
    assign in_fire     = item.valid && item.ready;
    assign cfg.ready   = 1'b1;

    assign rd_addr = IDX_W'(item.channel);
    assign s1_addr = IDX_W'(s1_channel_reg);

    mcpw_chan_mem #(
        .CHANNELS (CHANNELS)
    ) u_chan_mem (
        .clk        (clk),
        .rd_en      (in_fire),
        .rd_addr    (rd_addr),
        .wr_ctl     (wr_ctl),
        .wr_addr    (s1_addr),
        .wr_counter (s1_tick_reg),
        .wr_time    (s1_now_reg),
        .rd_counter (rd_counter),
        .rd_time    (rd_time)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= mcpw_pkg::CHANNEL_COUNT_RST;
            stall_limit_reg   <= mcpw_pkg::STALL_LIMIT_RST;
            poll_gap_reg      <= mcpw_pkg::POLL_GAP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mcpw_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg.data[mcpw_pkg::COUNT_W-1:0];
                mcpw_pkg::CFG_STALL_LIMIT:   stall_limit_reg   <= cfg.data;
                mcpw_pkg::CFG_POLL_GAP:      poll_gap_reg      <= cfg.data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg  <= item.action;
            s1_channel_reg <= item.channel;
            s1_tick_reg    <= item.tick_count;
            s1_now_reg     <= item.now_ms;
        end
    end

    assign ch_ok = ({1'b0, s1_channel_reg} < channel_count_reg)
                && ({3'b000, s1_channel_reg} < 7'(CHANNELS));
    assign gap   = s1_now_reg - last_poll_reg;
    assign stall = s1_now_reg - rd_time;

    always_comb
    begin
        status_next     = mcpw_pkg::ST_BAD;
        chout_next      = s1_channel_reg;
        stall_next      = '0;
        armed_mask_next = armed_mask_reg;
        last_poll_next  = last_poll_reg;
        rebase_next     = rebase_reg;
        max_stall_next  = max_stall_reg;
        hang_next       = hang_reg;
        wr_ctl          = '0;
        if (hang_reg)
        begin
            status_next = mcpw_pkg::ST_LATCHED;
            if (s1_action_reg == mcpw_pkg::ACT_POLL)
            begin
                chout_next = '0;
            end
        end
        else if (s1_action_reg == mcpw_pkg::ACT_POLL)
        begin
            rebase_next    = gap > {32'd0, poll_gap_reg};
            last_poll_next = s1_now_reg;
            status_next    = rebase_next ? mcpw_pkg::ST_REBASED : mcpw_pkg::ST_POLLED;
            chout_next     = '0;
        end
        else if (((s1_action_reg != mcpw_pkg::ACT_ARM)
                  && (s1_action_reg != mcpw_pkg::ACT_SAMPLE)) || !ch_ok)
        begin
            status_next = mcpw_pkg::ST_BAD;
        end
        else if (s1_action_reg == mcpw_pkg::ACT_ARM)
        begin
            wr_ctl.lc_we    = 1'b1;
            wr_ctl.pt_we    = 1'b1;
            armed_mask_next = armed_mask_reg | (CHANNELS'(1) << s1_addr);
            last_poll_next  = s1_now_reg;
            rebase_next     = 1'b0;
            status_next     = mcpw_pkg::ST_ARMED;
        end
        else if (!armed_mask_reg[s1_addr])
        begin
            status_next = mcpw_pkg::ST_BAD;
        end
        else if (rebase_reg)
        begin
            wr_ctl.pt_we = 1'b1;
            status_next  = mcpw_pkg::ST_REBASED;
        end
        else if (s1_tick_reg != rd_counter)
        begin
            wr_ctl.lc_we = 1'b1;
            wr_ctl.pt_we = 1'b1;
            status_next  = mcpw_pkg::ST_PROGRESS;
        end
        else
        begin
            stall_next = stall;
            if (stall > max_stall_reg)
            begin
                max_stall_next = stall;
            end
            if (stall >= {32'd0, stall_limit_reg})
            begin
                hang_next   = 1'b1;
                status_next = mcpw_pkg::ST_HANG;
            end
            else
            begin
                status_next = mcpw_pkg::ST_STALLED;
            end
        end
        // table writes only when the request leaves the input stage
        if (!s1_fire)
        begin
            wr_ctl = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_mask_reg <= '0;
            last_poll_reg  <= '0;
            rebase_reg     <= 1'b0;
            max_stall_reg  <= '0;
            hang_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                armed_mask_reg <= armed_mask_next;
                last_poll_reg  <= last_poll_next;
                rebase_reg     <= rebase_next;
                max_stall_reg  <= max_stall_next;
                hang_reg       <= hang_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            status_reg <= status_next;
            chout_reg  <= chout_next;
            stall_reg  <= stall_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.channel_out  = chout_reg;
    assign result.stall_ms     = stall_reg;
    assign result.max_stall_ms = max_stall_reg;
    assign result.hang         = hang_reg;

    // hang flag is sticky until reset
    a_hang_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        hang_reg |=> hang_reg)
        else $error("hang flag cleared without reset");

    // once hung, no table writes
    a_latched_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        hang_reg |-> (!wr_ctl.lc_we && !wr_ctl.pt_we))
        else $error("table written while hang latched");

    // running max never drops
    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (max_stall_reg >= $past(max_stall_reg)))
        else $error("max stall decreased");

    // armed channels stay armed
    a_armed_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((armed_mask_reg & $past(armed_mask_reg)) == $past(armed_mask_reg)))
        else $error("armed channel lost");

    // empty input stage always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> item.ready)
        else $error("input stalled while empty");

endmodule

FILE: test/multi_channel_progress_watchdog_tb.sv
// self-checking testbench of the multi-channel progress watchdog
// scoreboard class predicts each result from accepted requests; tasks drive requests
// depends on mcpw_pkg, mcpw_ifs and multi_channel_progress_watchdog
`timescale 1ns / 100ps

module multi_channel_progress_watchdog_tb;

    localparam int NUM_CH = 16;
    localparam logic [mcpw_pkg::ACT_W-1:0] ACT_BOGUS = 2'd3;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        logic [mcpw_pkg::ACT_W-1:0]  action;
        logic [mcpw_pkg::CH_W-1:0]   channel;
        logic [mcpw_pkg::TICK_W-1:0] tick;
        logic [mcpw_pkg::TIME_W-1:0] now;
    } watch_req_t;

    typedef struct {
        mcpw_pkg::status_t           status;
        logic [mcpw_pkg::CH_W-1:0]   channel;
        logic [mcpw_pkg::TIME_W-1:0] stall;
        logic [mcpw_pkg::TIME_W-1:0] max_stall;
        logic                        hang;
    } verdict_t;

    class watchdog_scoreboard;
        logic [mcpw_pkg::TICK_W-1:0]  last_tick [NUM_CH];
        logic [mcpw_pkg::TIME_W-1:0]  progress_at [NUM_CH];
        logic [NUM_CH-1:0]            armed;
        logic [mcpw_pkg::TIME_W-1:0]  poll_mark;
        logic                         rebasing;
        logic [mcpw_pkg::TIME_W-1:0]  peak_stall;
        logic                         hang_seen;
        logic [mcpw_pkg::COUNT_W-1:0] chan_limit;
        logic [mcpw_pkg::LIMIT_W-1:0] stall_limit;
        logic [mcpw_pkg::LIMIT_W-1:0] gap_limit;
        verdict_t                     verdict_q [$];
        int                           mismatches;

        function new();
            armed       = '0;
            poll_mark   = '0;
            rebasing    = 1'b0;
            peak_stall  = '0;
            hang_seen   = 1'b0;
            chan_limit  = mcpw_pkg::CHANNEL_COUNT_RST;
            stall_limit = mcpw_pkg::STALL_LIMIT_RST;
            gap_limit   = mcpw_pkg::POLL_GAP_RST;
            mismatches  = 0;
        endfunction

        function void set_register(logic [mcpw_pkg::CFG_IDX_W-1:0] idx,
                                   logic [mcpw_pkg::LIMIT_W-1:0] val);
            if (idx == mcpw_pkg::CFG_CHANNEL_COUNT)
                chan_limit = val[mcpw_pkg::COUNT_W-1:0];
            else if (idx == mcpw_pkg::CFG_STALL_LIMIT)
                stall_limit = val;
            else if (idx == mcpw_pkg::CFG_POLL_GAP)
                gap_limit = val;
        endfunction

        function bit channel_ok(logic [mcpw_pkg::CH_W-1:0] ch);
            return (mcpw_pkg::COUNT_W'(ch) < chan_limit) && (int'(ch) < NUM_CH);
        endfunction

        function bit would_hang(watch_req_t r);
            if (hang_seen || r.action != mcpw_pkg::ACT_SAMPLE || !channel_ok(r.channel))
                return 1'b0;
            if (!armed[r.channel] || rebasing || r.tick != last_tick[r.channel])
                return 1'b0;
            return (r.now - progress_at[r.channel]) >= mcpw_pkg::TIME_W'(stall_limit);
        endfunction

        function verdict_t judge(watch_req_t r);
            verdict_t v;
            logic [mcpw_pkg::TIME_W-1:0] stall;
            v.status  = mcpw_pkg::ST_BAD;
            v.channel = r.channel;
            v.stall   = '0;
            if (hang_seen)
            begin
                v.status = mcpw_pkg::ST_LATCHED;
                if (r.action == mcpw_pkg::ACT_POLL)
                    v.channel = '0;
            end
            else if (r.action == mcpw_pkg::ACT_POLL)
            begin
                rebasing  = (r.now - poll_mark) > mcpw_pkg::TIME_W'(gap_limit);
                poll_mark = r.now;
                v.status  = rebasing ? mcpw_pkg::ST_REBASED : mcpw_pkg::ST_POLLED;
                v.channel = '0;
            end
            else if (r.action == ACT_BOGUS || !channel_ok(r.channel))
                v.status = mcpw_pkg::ST_BAD;
            else if (r.action == mcpw_pkg::ACT_ARM)
            begin
                last_tick[r.channel]   = r.tick;
                progress_at[r.channel] = r.now;
                armed[r.channel]       = 1'b1;
                poll_mark              = r.now;
                rebasing               = 1'b0;
                v.status               = mcpw_pkg::ST_ARMED;
            end
            else if (!armed[r.channel])
                v.status = mcpw_pkg::ST_BAD;
            else if (rebasing)
            begin
                progress_at[r.channel] = r.now;
                v.status               = mcpw_pkg::ST_REBASED;
            end
            else if (r.tick != last_tick[r.channel])
            begin
                last_tick[r.channel]   = r.tick;
                progress_at[r.channel] = r.now;
                v.status               = mcpw_pkg::ST_PROGRESS;
            end
            else
            begin
                stall   = r.now - progress_at[r.channel];
                v.stall = stall;
                if (stall > peak_stall)
                    peak_stall = stall;
                if (stall >= mcpw_pkg::TIME_W'(stall_limit))
                begin
                    hang_seen = 1'b1;
                    v.status  = mcpw_pkg::ST_HANG;
                end
                else
                    v.status = mcpw_pkg::ST_STALLED;
            end
            v.max_stall = peak_stall;
            v.hang      = hang_seen;
            return v;
        endfunction

        function void note_request(watch_req_t r);
            verdict_q.push_back(judge(r));
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        task log_mismatch(string msg);
            $display("%0t ns mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(verdict_t got);
            verdict_t want;
            if (verdict_q.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result status %0d channel %0d",
                                       got.status, got.channel));
                return;
            end
            want = verdict_q.pop_front();
            if (got.status !== want.status)
                log_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.channel !== want.channel)
                log_mismatch($sformatf("channel %0d, expected %0d", got.channel,
                                       want.channel));
            if (got.stall !== want.stall)
                log_mismatch($sformatf("stall_ms %0h, expected %0h", got.stall, want.stall));
            if (got.max_stall !== want.max_stall)
                log_mismatch($sformatf("max_stall_ms %0h, expected %0h", got.max_stall,
                                       want.max_stall));
            if (got.hang !== want.hang)
                log_mismatch($sformatf("hang %b, expected %b", got.hang, want.hang));
        endtask
    endclass

    logic clk;
    logic rst_n;

    mcpw_item_if   req_ch ();
    mcpw_result_if res_ch ();
    mcpw_cfg_if    cfg_ch ();

    multi_channel_progress_watchdog #(
        .CHANNELS(NUM_CH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(req_ch),
        .result(res_ch),
        .cfg(cfg_ch)
    );

    watchdog_scoreboard          sb;
    logic [mcpw_pkg::TIME_W-1:0] wall_ms;
    int                          sent_n;
    int                          got_n;

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("multi_channel_progress_watchdog test failed");
        $finish;
    end

    function automatic watch_req_t make_req(logic [mcpw_pkg::ACT_W-1:0] act,
                                            logic [mcpw_pkg::CH_W-1:0] ch,
                                            logic [mcpw_pkg::TICK_W-1:0] tick,
                                            logic [mcpw_pkg::TIME_W-1:0] now);
        watch_req_t r;
        r.action  = act;
        r.channel = ch;
        r.tick    = tick;
        r.now     = now;
        return r;
    endfunction

    function automatic watch_req_t draw_request();
        watch_req_t r;
        int pick;
        int lim;
        logic [mcpw_pkg::CH_W-1:0] live [$];
        case ($urandom_range(0, 49))
            0:                      wall_ms = {$urandom, $urandom};
            1, 2, 3:                wall_ms += $urandom;
            4, 5, 6, 7, 8, 9, 10:   wall_ms += $urandom_range(0, 20000);
            default:                wall_ms += $urandom_range(0, 1500);
        endcase
        r.now     = wall_ms;
        r.tick    = {$urandom, $urandom};
        r.channel = mcpw_pkg::CH_W'($urandom_range(0, NUM_CH - 1));
        r.action  = mcpw_pkg::ACT_SAMPLE;
        lim = (int'(sb.chan_limit) > NUM_CH) ? NUM_CH : int'(sb.chan_limit);
        for (int c = 0; c < lim; c++)
            if (sb.armed[c])
                live.push_back(mcpw_pkg::CH_W'(c));
        pick = $urandom_range(0, 99);
        if (pick < 8 || (live.size() == 0 && pick < 85))
        begin
            r.action = mcpw_pkg::ACT_ARM;
            if (lim > 0)
                r.channel = mcpw_pkg::CH_W'($urandom_range(0, lim - 1));
        end
        else if (pick < 22)
            r.action = mcpw_pkg::ACT_POLL;
        else if (pick < 85)
        begin
            r.channel = live[$urandom_range(0, live.size() - 1)];
            if ($urandom_range(0, 1))
                r.tick = sb.last_tick[r.channel];
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: r.action = ACT_BOGUS;
                1:
                begin
                    r.action = $urandom_range(0, 1) ? mcpw_pkg::ACT_ARM
                                                    : mcpw_pkg::ACT_SAMPLE;
                    if (lim < NUM_CH)
                        r.channel = mcpw_pkg::CH_W'($urandom_range(lim, NUM_CH - 1));
                end
                2: r.action = mcpw_pkg::ACT_SAMPLE;
                default: r.action = mcpw_pkg::ACT_W'($urandom_range(0, 3));
            endcase
        end
        if (sb.would_hang(r))
            r.tick = ~r.tick;
        return r;
    endfunction

    task automatic send_request(watch_req_t r);
        int gap;
        gap = ((sent_n % 100) < 30) ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= r.action;
        req_ch.channel    <= r.channel;
        req_ch.tick_count <= r.tick;
        req_ch.now_ms     <= r.now;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(r);
        sent_n++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic [mcpw_pkg::CFG_IDX_W-1:0] idx,
                                  logic [mcpw_pkg::LIMIT_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : result_sink
        int hold;
        verdict_t got;
        hold = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
                res_ch.ready <= 1'b1;
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.status    = mcpw_pkg::status_t'(res_ch.status);
                got.channel   = res_ch.channel_out;
                got.stall     = res_ch.stall_ms;
                got.max_stall = res_ch.max_stall_ms;
                got.hang      = res_ch.hang;
                sb.check_result(got);
                got_n++;
                // long back-pressure so the request side fills and stalls
                if (got_n == 250 || got_n == 600)
                    hold = 300;
                else if ((got_n % 90) < 25)
                    hold = 0;
                else
                    hold = $urandom_range(0, 13);
            end
        end
    end

    initial
    begin
        logic [mcpw_pkg::TICK_W-1:0]  tick_a;
        logic [mcpw_pkg::LIMIT_W-1:0] cnt_val;
        logic [mcpw_pkg::LIMIT_W-1:0] stall_val;
        logic [mcpw_pkg::LIMIT_W-1:0] gap_val;
        sb     = new();
        sent_n = 0;
        got_n  = 0;
        rst_n  = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = mcpw_pkg::ACT_ARM;
        req_ch.channel    = '0;
        req_ch.tick_count = '0;
        req_ch.now_ms     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = mcpw_pkg::CFG_CHANNEL_COUNT;
        cfg_ch.data       = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        tick_a = {$urandom, $urandom};
        // sample of a never-armed channel, unknown action
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd5, 64'd0, 64'd100));
        send_request(make_req(ACT_BOGUS, 4'd2, 64'd0, 64'd100));
        send_request(make_req(mcpw_pkg::ACT_ARM, 4'd0, 64'd0, 64'd0));
        send_request(make_req(mcpw_pkg::ACT_ARM, 4'd15, '1, 64'd1000));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd15, '1, 64'd3000));
        send_request(make_req(mcpw_pkg::ACT_POLL, 4'd0, 64'd0, 64'd4000));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd0, 64'd5, 64'd4000));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd0, 64'd5, 64'd9000));
        // poll gap over the limit, then rebased samples
        send_request(make_req(mcpw_pkg::ACT_POLL, 4'd0, 64'd0, 64'd14001));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd0, 64'd5, 64'd14001));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd15, '1, 64'd14001));
        send_request(make_req(mcpw_pkg::ACT_POLL, 4'd15, tick_a, 64'd14002));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd0, 64'd5, 64'd24000));
        // time wraps around zero
        send_request(make_req(mcpw_pkg::ACT_ARM, 4'd7, tick_a, '1));
        send_request(make_req(mcpw_pkg::ACT_POLL, 4'd0, 64'd0, 64'd0));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd7, tick_a, 64'd1));
        drain_results();

        write_register(mcpw_pkg::CFG_CHANNEL_COUNT, 32'd0);
        send_request(make_req(mcpw_pkg::ACT_ARM, 4'd0, 64'd9, 64'd24002));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd0, 64'd5, 64'd24002));
        drain_results();
        write_register(mcpw_pkg::CFG_CHANNEL_COUNT, 32'd4);
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd15, '1, 64'd24003));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd0, 64'd6, 64'd24003));
        drain_results();

        wall_ms = {$urandom, $urandom};
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    cnt_val   = 32'd16;
                    stall_val = mcpw_pkg::STALL_LIMIT_RST;
                    gap_val   = mcpw_pkg::POLL_GAP_RST;
                end
                1:
                begin
                    cnt_val   = 32'd1;
                    stall_val = 32'd1;
                    gap_val   = 32'd1;
                end
                2:
                begin
                    cnt_val   = 32'd31;
                    stall_val = '1;
                    gap_val   = '1;
                end
                3:
                begin
                    cnt_val   = $urandom_range(2, 15);
                    stall_val = $urandom_range(2000, 60000);
                    gap_val   = $urandom_range(500, 20000);
                end
                default:
                begin
                    cnt_val   = 32'd16;
                    stall_val = $urandom | 32'd1;
                    gap_val   = $urandom | 32'd1;
                end
            endcase
            write_register(mcpw_pkg::CFG_CHANNEL_COUNT, cnt_val);
            write_register(mcpw_pkg::CFG_STALL_LIMIT, stall_val);
            write_register(mcpw_pkg::CFG_POLL_GAP, gap_val);
            repeat (PHASE_ITEMS)
                send_request(draw_request());
            drain_results();
        end

        // zero stall limit turns the next stall into a hang, then everything latches
        write_register(mcpw_pkg::CFG_CHANNEL_COUNT, 32'd16);
        write_register(mcpw_pkg::CFG_STALL_LIMIT, 32'd0);
        send_request(make_req(mcpw_pkg::ACT_ARM, 4'd3, tick_a, wall_ms));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd3, tick_a, wall_ms + 64'd7));
        send_request(make_req(mcpw_pkg::ACT_POLL, 4'd9, tick_a, wall_ms + 64'd8));
        send_request(make_req(mcpw_pkg::ACT_ARM, 4'd2, 64'd1, wall_ms + 64'd9));
        send_request(make_req(mcpw_pkg::ACT_SAMPLE, 4'd3, tick_a, wall_ms + 64'd10));
        send_request(make_req(ACT_BOGUS, 4'd9, 64'd0, wall_ms + 64'd11));
        drain_results();
        write_register(mcpw_pkg::CFG_POLL_GAP, 32'd77);
        send_request(make_req(mcpw_pkg::ACT_POLL, 4'd0, 64'd0, wall_ms + 64'd200));
        drain_results();
        repeat (10) @(negedge clk);

        if (sb.mismatches == 0)
            $display("multi_channel_progress_watchdog test passed");
        else
            $display("multi_channel_progress_watchdog test failed");
        $finish;
    end

endmodule
